>>> hdl/ash_pkg.sv
package ash_pkg;

    localparam int MAX_BINS      = 64;
    localparam int NUM_INTERVALS = 2;
    localparam int VW            = 32;
    localparam int EDGE_DEPTH    = MAX_BINS + 1;
    localparam int EDGE_AW       = $clog2(EDGE_DEPTH);
    localparam int CNT_AW        = $clog2(MAX_BINS);
    localparam int NB_W          = $clog2(MAX_BINS + 1);
    localparam int DIV_CW        = $clog2(VW + 1);

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_BAR   = 3'd1,
        CMD_INTV  = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_RANGE = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        REG_INIT_LOW  = 3'd0,
        REG_INIT_HIGH = 3'd1,
        REG_MIN_SPLIT = 3'd2,
        REG_NUM_INTV  = 3'd3,
        REG_A_LOW     = 3'd4,
        REG_A_HIGH    = 3'd5,
        REG_B_LOW     = 3'd6,
        REG_B_HIGH    = 3'd7
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE, S_RR0, S_RR1, S_CLR,
        S_A0, S_A1, S_A2, S_BS, S_BSC, S_OW, S_UW, S_UF,
        S_SH, S_SHL,
        S_BUMP, S_B1, S_B2, S_CHK, S_MUL, S_DIV0, S_DIVW, S_SP1, S_SP2,
        S_R1, S_R2, S_OUT
    } t_state;

    typedef enum logic {
        AFT_UNDER,
        AFT_SPLIT
    } t_after;

    typedef struct packed {
        logic                start;
        logic [2*VW-1:0]     num;
        logic [VW-1:0]       den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [VW-1:0]       quo;
        logic                rem_nz;
    } t_div_rsp;

    function automatic logic [VW-1:0] sat_fix(input logic [VW:0] s);
        if (s[VW] != s[VW-1]) begin
            sat_fix = s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            sat_fix = s[VW-1:0];
        end
    endfunction

    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a,
                                              input logic [VW-1:0] b);
        sat_add = sat_fix({a[VW-1], a} + {b[VW-1], b});
    endfunction

    function automatic logic [VW-1:0] sat_sub(input logic [VW-1:0] a,
                                              input logic [VW-1:0] b);
        sat_sub = sat_fix({a[VW-1], a} - {b[VW-1], b});
    endfunction

    function automatic logic [VW-1:0] inc_sat(input logic [VW-1:0] a);
        inc_sat = (&a) ? a : a + 1'b1;
    endfunction

endpackage

>>> hdl/adaptive_split_histogram.sv
// One request at a time; input stall is high from acceptance until the result is loaded.
// Add: a binary search over the edges places a sample in range; growth above the range
// writes the new edge and count directly, growth below the range shifts all edges and
// counts up by one, and a split of bin b runs a serial divide, then shifts the edges and
// counts above b. After reset a pass rebuilds the single default bin and zeroes counts.
module adaptive_split_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_sample_value,
    input  logic [5:0]  i_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_bar_low,
    output logic [31:0] o_bar_high,
    output logic [31:0] o_hit_count,
    output logic [31:0] o_total_samples,
    output logic [6:0]  o_bars_in_use,
    output logic        o_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ash_pkg::*;

    // configuration
    logic [VW-1:0] r_init_low, r_init_high, r_a_low, r_a_high, r_b_low, r_b_high;
    logic [30:0]   r_min_split;
    logic [1:0]    r_num_intv;
    t_reg          reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_low  <= '0;
            r_init_high <= VW'(65536);
            r_min_split <= '0;
            r_num_intv  <= '0;
            r_a_low     <= '0;
            r_a_high    <= '0;
            r_b_low     <= '0;
            r_b_high    <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_INIT_LOW:  r_init_low  <= pwdata;
                REG_INIT_HIGH: r_init_high <= pwdata;
                REG_MIN_SPLIT: r_min_split <= pwdata[30:0];
                REG_NUM_INTV:  r_num_intv  <= pwdata[1:0];
                REG_A_LOW:     r_a_low     <= pwdata;
                REG_A_HIGH:    r_a_high    <= pwdata;
                REG_B_LOW:     r_b_low     <= pwdata;
                REG_B_HIGH:    r_b_high    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_INIT_LOW:  prdata = r_init_low;
            REG_INIT_HIGH: prdata = r_init_high;
            REG_MIN_SPLIT: prdata = {1'b0, r_min_split};
            REG_NUM_INTV:  prdata = {30'd0, r_num_intv};
            REG_A_LOW:     prdata = r_a_low;
            REG_A_HIGH:    prdata = r_a_high;
            REG_B_LOW:     prdata = r_b_low;
            REG_B_HIGH:    prdata = r_b_high;
            default:       prdata = '0;
        endcase
    end

    // memories
    logic [VW-1:0] r_edge_mem [0:EDGE_DEPTH-1];
    logic [VW-1:0] r_cnt_mem  [0:MAX_BINS-1];
    logic [VW-1:0] r_edge_q, r_cnt_q;
    logic [EDGE_AW-1:0] edge_ra, edge_wa;
    logic [CNT_AW-1:0]  cnt_ra, cnt_wa;
    logic               edge_we, cnt_we;
    logic [VW-1:0]      edge_wd, cnt_wd;

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[edge_wa] <= edge_wd;
        end
        r_edge_q <= r_edge_mem[edge_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        r_cnt_q <= r_cnt_mem[cnt_ra];
    end

    // shared multiplier
    logic [VW-1:0]   mul_a, mul_b;
    logic [2*VW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    t_div_req div_req;
    t_div_rsp div_rsp;

    ash_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer state
    t_state r_state, n_state;
    t_after r_after, n_after;
    logic [NB_W-1:0]    r_nb, n_nb;
    logic [VW-1:0]      r_total, n_total, r_hit0, n_hit0, r_hit1, n_hit1;
    logic [VW-1:0]      r_v, n_v, r_e0, n_e0, r_en, n_en, r_nl, n_nl, r_m, n_m;
    logic [VW-1:0]      r_bl, n_bl, r_bh, n_bh, r_hc, n_hc;
    logic [CNT_AW-1:0]  r_idx, n_idx, r_b, n_b;
    logic [NB_W-1:0]    r_lo, n_lo, r_up, n_up, r_mid, n_mid;
    logic [NB_W-1:0]    r_k, n_k, r_wk, n_wk, r_base, n_base;
    logic               r_pend, n_pend, r_sat, n_sat, r_out_pend, n_out_pend;
    logic               r_ov, n_ov;
    logic [VW-1:0]      r_o_bl, n_o_bl, r_o_bh, n_o_bh, r_o_hc, n_o_hc, r_o_tot, n_o_tot;
    logic [NB_W-1:0]    r_o_nb, n_o_nb;
    logic               r_o_sat, n_o_sat;

    logic [1:0]      nact;
    logic [VW-1:0]   half_up, half_low, w, mq;
    logic [VW:0]     msum;
    logic [NB_W-1:0] b_ext;
    t_cmd            cmd;

    assign nact    = (r_num_intv > 2'(NUM_INTERVALS)) ? 2'(NUM_INTERVALS) : r_num_intv;
    assign half_up = r_hc >> 1;
    assign half_low = r_hc - half_up;
    assign b_ext   = NB_W'(r_b);
    assign cmd     = t_cmd'(i_cmd);
    assign msum    = {r_bl[VW-1], r_bl} + {1'b0, div_rsp.quo};

    always_comb begin
        n_state = r_state;   n_after = r_after;  n_nb = r_nb;
        n_total = r_total;   n_hit0 = r_hit0;    n_hit1 = r_hit1;
        n_v = r_v;           n_e0 = r_e0;        n_en = r_en;
        n_nl = r_nl;         n_m = r_m;          n_bl = r_bl;
        n_bh = r_bh;         n_hc = r_hc;        n_idx = r_idx;
        n_b = r_b;           n_lo = r_lo;        n_up = r_up;
        n_mid = r_mid;       n_k = r_k;          n_wk = r_wk;
        n_base = r_base;     n_pend = r_pend;    n_sat = r_sat;
        n_out_pend = r_out_pend;
        n_ov = r_ov & i_out_stall;
        n_o_bl = r_o_bl;     n_o_bh = r_o_bh;    n_o_hc = r_o_hc;
        n_o_tot = r_o_tot;   n_o_nb = r_o_nb;    n_o_sat = r_o_sat;
        edge_ra = '0;  edge_we = 1'b0;  edge_wa = '0;  edge_wd = '0;
        cnt_ra  = '0;  cnt_we  = 1'b0;  cnt_wa  = '0;  cnt_wd  = '0;
        mul_a = r_hc;  mul_b = r_hc;
        div_req.start = 1'b0;
        div_req.num   = r_prod;
        div_req.den   = r_hc;
        w  = '0;
        mq = msum[VW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_v = i_sample_value;
                    n_idx = i_index;
                    n_sat = 1'b0;
                    n_bl = '0;
                    n_bh = '0;
                    n_hc = '0;
                    n_out_pend = 1'b1;
                    case (cmd)
                        CMD_ADD: begin
                            if (nact > 2'd0 && $signed(i_sample_value) >= $signed(r_a_low)
                                && $signed(i_sample_value) <= $signed(r_a_high)) begin
                                n_hit0 = inc_sat(r_hit0);
                            end
                            if (nact > 2'd1 && $signed(i_sample_value) >= $signed(r_b_low)
                                && $signed(i_sample_value) <= $signed(r_b_high)) begin
                                n_hit1 = inc_sat(r_hit1);
                            end
                            n_state = S_A0;
                        end
                        CMD_BAR: begin
                            if (NB_W'(i_index) < r_nb) begin
                                edge_ra = EDGE_AW'(i_index);
                                cnt_ra = i_index;
                                n_state = S_R1;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        CMD_INTV: begin
                            if (i_index < {4'd0, nact}) begin
                                n_bl = i_index[0] ? r_b_low : r_a_low;
                                n_bh = i_index[0] ? r_b_high : r_a_high;
                                n_hc = i_index[0] ? r_hit1 : r_hit0;
                            end
                            n_state = S_OUT;
                        end
                        CMD_CLEAR: begin
                            n_total = '0;
                            n_hit0 = '0;
                            n_hit1 = '0;
                            n_k = '0;
                            n_state = S_CLR;
                        end
                        CMD_RANGE: begin
                            n_total = '0;
                            n_hit0 = '0;
                            n_hit1 = '0;
                            n_e0 = r_init_low;
                            n_en = r_init_high;
                            n_state = S_RR0;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_RR0: begin
                edge_we = 1'b1;
                edge_wa = '0;
                edge_wd = r_e0;
                n_state = S_RR1;
            end
            S_RR1: begin
                edge_we = 1'b1;
                edge_wa = EDGE_AW'(1);
                edge_wd = r_en;
                n_nb = NB_W'(1);
                n_k = '0;
                n_state = S_CLR;
            end
            S_CLR: begin
                cnt_we = 1'b1;
                cnt_wa = r_k[CNT_AW-1:0];
                cnt_wd = '0;
                n_k = r_k + 1'b1;
                if (r_k[CNT_AW-1:0] == CNT_AW'(MAX_BINS - 1)) begin
                    n_state = r_out_pend ? S_OUT : S_IDLE;
                end
            end
            S_A0: begin
                edge_ra = '0;
                n_state = S_A1;
            end
            S_A1: begin
                n_e0 = r_edge_q;
                edge_ra = EDGE_AW'(r_nb);
                n_state = S_A2;
            end
            S_A2: begin
                n_en = r_edge_q;
                if ($signed(r_v) < $signed(r_e0)) begin
                    if (r_nb < NB_W'(MAX_BINS)) begin
                        edge_ra = EDGE_AW'(1);
                        n_state = S_UW;
                    end else begin
                        n_sat = 1'b1;
                        n_b = '0;
                        n_state = S_BUMP;
                    end
                end else if ($signed(r_v) >= $signed(r_edge_q)) begin
                    if (r_nb < NB_W'(MAX_BINS)) begin
                        edge_ra = EDGE_AW'(r_nb - 1'b1);
                        n_state = S_OW;
                    end else begin
                        n_sat = 1'b1;
                        n_b = CNT_AW'(r_nb - 1'b1);
                        n_state = S_BUMP;
                    end
                end else begin
                    n_lo = '0;
                    n_up = r_nb;
                    n_state = S_BS;
                end
            end
            S_BS: begin
                if (r_up - r_lo > NB_W'(1)) begin
                    n_mid = NB_W'((r_up + r_lo) >> 1);
                    edge_ra = EDGE_AW'(n_mid);
                    n_state = S_BSC;
                end else begin
                    n_b = CNT_AW'(r_lo);
                    n_state = S_BUMP;
                end
            end
            S_BSC: begin
                if ($signed(r_v) < $signed(r_edge_q)) begin
                    n_up = r_mid;
                end else begin
                    n_lo = r_mid;
                end
                n_state = S_BS;
            end
            S_OW: begin
                w = sat_sub(r_en, r_edge_q);
                edge_we = 1'b1;
                edge_wa = EDGE_AW'(r_nb + 1'b1);
                edge_wd = sat_add(r_v, w);
                cnt_we = 1'b1;
                cnt_wa = CNT_AW'(r_nb);
                cnt_wd = '0;
                n_b = CNT_AW'(r_nb);
                n_nb = r_nb + 1'b1;
                n_state = S_BUMP;
            end
            S_UW: begin
                w = sat_sub(r_e0, r_edge_q);
                n_nl = sat_add(r_v, w);
                n_k = r_nb;
                n_base = '0;
                n_pend = 1'b0;
                n_after = AFT_UNDER;
                n_state = S_SH;
            end
            S_UF: begin
                edge_we = 1'b1;
                edge_wa = '0;
                edge_wd = r_nl;
                cnt_we = 1'b1;
                cnt_wa = '0;
                cnt_wd = '0;
                n_nb = r_nb + 1'b1;
                n_b = '0;
                n_state = S_BUMP;
            end
            // move edges [base..nb] and counts [base..nb-1] up by one, top first
            S_SH, S_SHL: begin
                if (r_pend) begin
                    edge_we = 1'b1;
                    edge_wa = EDGE_AW'(r_wk + 1'b1);
                    edge_wd = r_edge_q;
                    if (r_wk < r_nb) begin
                        cnt_we = 1'b1;
                        cnt_wa = CNT_AW'(r_wk + 1'b1);
                        cnt_wd = r_cnt_q;
                    end
                end
                if (r_state == S_SH) begin
                    edge_ra = EDGE_AW'(r_k);
                    cnt_ra = r_k[CNT_AW-1:0];
                    n_wk = r_k;
                    n_pend = 1'b1;
                    if (r_k == r_base) begin
                        n_state = S_SHL;
                    end else begin
                        n_k = r_k - 1'b1;
                    end
                end else begin
                    n_pend = 1'b0;
                    n_state = (r_after == AFT_UNDER) ? S_UF : S_SP1;
                end
            end
            S_BUMP: begin
                edge_ra = EDGE_AW'(r_b);
                cnt_ra = r_b;
                n_state = S_B1;
            end
            S_B1: begin
                n_bl = r_edge_q;
                n_hc = inc_sat(r_cnt_q);
                cnt_we = 1'b1;
                cnt_wa = r_b;
                cnt_wd = n_hc;
                n_total = inc_sat(r_total);
                edge_ra = EDGE_AW'(b_ext + 1'b1);
                n_state = S_B2;
            end
            S_B2: begin
                n_bh = r_edge_q;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_nb < NB_W'(MAX_BINS) && r_prod > {{VW{1'b0}}, r_total}
                    && $signed(sat_sub(r_bh, r_bl)) > $signed({1'b0, r_min_split})) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                mul_a = r_bh - r_bl;
                mul_b = half_low;
                n_state = S_DIV0;
            end
            S_DIV0: begin
                div_req.start = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    // truncate toward zero for a negative edge
                    if (mq[VW-1] && div_rsp.rem_nz) begin
                        mq = mq + 1'b1;
                    end
                    n_m = mq;
                    n_k = r_nb;
                    n_base = b_ext + 1'b1;
                    n_pend = 1'b0;
                    n_after = AFT_SPLIT;
                    n_state = S_SH;
                end
            end
            S_SP1: begin
                cnt_we = 1'b1;
                cnt_wa = r_b;
                cnt_wd = half_low;
                edge_we = 1'b1;
                edge_wa = EDGE_AW'(b_ext + 1'b1);
                edge_wd = r_m;
                n_state = S_SP2;
            end
            S_SP2: begin
                cnt_we = 1'b1;
                cnt_wa = CNT_AW'(b_ext + 1'b1);
                cnt_wd = half_up;
                n_nb = r_nb + 1'b1;
                n_state = S_OUT;
            end
            S_R1: begin
                n_bl = r_edge_q;
                n_hc = r_cnt_q;
                edge_ra = EDGE_AW'(NB_W'(r_idx) + 1'b1);
                n_state = S_R2;
            end
            S_R2: begin
                n_bh = r_edge_q;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_o_bl = r_bl;
                    n_o_bh = r_bh;
                    n_o_hc = r_hc;
                    n_o_tot = r_total;
                    n_o_nb = r_nb;
                    n_o_sat = r_sat;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RR0;
            r_out_pend <= 1'b0;
            r_ov <= 1'b0;
            r_nb <= NB_W'(1);
            r_total <= '0;
            r_hit0 <= '0;
            r_hit1 <= '0;
            r_e0 <= '0;
            r_en <= VW'(65536);
            r_pend <= 1'b0;
            r_after <= AFT_UNDER;
        end else begin
            r_state <= n_state;
            r_out_pend <= n_out_pend;
            r_ov <= n_ov;
            r_nb <= n_nb;
            r_total <= n_total;
            r_hit0 <= n_hit0;
            r_hit1 <= n_hit1;
            r_e0 <= n_e0;
            r_en <= n_en;
            r_pend <= n_pend;
            r_after <= n_after;
        end
        r_v <= n_v;      r_nl <= n_nl;    r_m <= n_m;
        r_bl <= n_bl;    r_bh <= n_bh;    r_hc <= n_hc;
        r_idx <= n_idx;  r_b <= n_b;      r_lo <= n_lo;
        r_up <= n_up;    r_mid <= n_mid;  r_k <= n_k;
        r_wk <= n_wk;    r_base <= n_base; r_sat <= n_sat;
        r_o_bl <= n_o_bl; r_o_bh <= n_o_bh; r_o_hc <= n_o_hc;
        r_o_tot <= n_o_tot; r_o_nb <= n_o_nb; r_o_sat <= n_o_sat;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_bar_low       = r_o_bl;
    assign o_bar_high      = r_o_bh;
    assign o_hit_count     = r_o_hc;
    assign o_total_samples = r_o_tot;
    assign o_bars_in_use   = r_o_nb;
    assign o_saturated     = r_o_sat;

    a_nb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nb != '0 && r_nb <= NB_W'(MAX_BINS))
        else $error("bin count out of range");

    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_sat |-> r_o_nb == NB_W'(MAX_BINS))
        else $error("saturated result without a full bin store");

    a_nb_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nb < $past(r_nb) |-> r_nb == NB_W'(1))
        else $error("bin count dropped other than by range reset");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIVW)
        else $error("divide finished outside its wait state");

endmodule

>>> hdl/ash_div.sv
module ash_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ash_pkg::t_div_req i_req,
    output ash_pkg::t_div_rsp o_rsp
);
    import ash_pkg::*;

    logic [VW-1:0]     r_rem, r_quo, r_den;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [VW:0]       sh;
    logic [VW:0]       diff;

    // restoring divide, one quotient bit a cycle; high half of the dividend is below den
    assign sh   = {r_rem, r_quo[VW-1]};
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.num[2*VW-1:VW];
                r_quo  <= i_req.num[VW-1:0];
                r_den  <= i_req.den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!diff[VW]) begin
                    r_rem <= diff[VW-1:0];
                    r_quo <= {r_quo[VW-2:0], 1'b1};
                end else begin
                    r_rem <= sh[VW-1:0];
                    r_quo <= {r_quo[VW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(VW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quo    = r_quo;
    assign o_rsp.rem_nz = |r_rem;

endmodule

>>> bench/adaptive_split_histogram_tb.sv
`timescale 1ns / 100ps

module adaptive_split_histogram_tb;
    import ash_pkg::*;

    localparam int NBINS = 64;
    localparam longint VMAXL = 64'sd2147483647;
    localparam longint VMINL = -64'sd2147483648;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] sample;
        logic [5:0]  index;
    } t_request;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] hits;
        logic [31:0] total;
        logic [6:0]  nbars;
        logic        sat;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_cmd;
    logic [31:0] i_sample_value;
    logic [5:0]  i_index;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_bar_low;
    logic [31:0] o_bar_high;
    logic [31:0] o_hit_count;
    logic [31:0] o_total_samples;
    logic [6:0]  o_bars_in_use;
    logic        o_saturated;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    adaptive_split_histogram uut (.*);

    // histogram shadow state
    longint      edges[NBINS + 1];
    logic [31:0] counts[NBINS];
    int          nbins;
    logic [31:0] total;
    logic [31:0] ihits[2];
    logic [31:0] cfg[8];

    t_request    pending_q[$];
    t_answer     answer_q[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          errors;
    int          n_results;
    int          n_adds;
    int          n_splits;
    longint      cycle;

    function automatic longint sx(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sadd(longint a, longint b);
        longint s;
        s = a + b;
        if (s > VMAXL) return VMAXL;
        if (s < VMINL) return VMINL;
        return s;
    endfunction

    function automatic logic [31:0] inc32(logic [31:0] v);
        return (&v) ? v : v + 32'd1;
    endfunction

    function automatic int n_active();
        return (cfg[REG_NUM_INTV] > 2) ? 2 : int'(cfg[REG_NUM_INTV]);
    endfunction

    task automatic clear_counts();
        for (int i = 0; i < NBINS; i++) counts[i] = '0;
        ihits[0] = '0;
        ihits[1] = '0;
        total = '0;
    endtask

    task automatic restart_range();
        for (int i = 0; i <= NBINS; i++) edges[i] = 0;
        edges[0] = sx(cfg[REG_INIT_LOW]);
        edges[1] = sx(cfg[REG_INIT_HIGH]);
        nbins = 1;
        clear_counts();
    endtask

    // edge between the two halves: lo + (hi-lo)*l/c, truncated toward zero
    function automatic longint split_edge(longint lo, longint hi, logic [31:0] l,
                                          logic [31:0] c);
        logic [127:0] prod;
        logic [63:0]  q;
        logic [63:0]  r;
        longint       res;
        prod = {64'd0, 64'(hi - lo)} * {96'd0, l};
        q = 64'(prod / {96'd0, c});
        r = 64'(prod % {96'd0, c});
        res = 64'(64'(lo) + q);
        if (res < 0 && r != 0) res = res + 1;
        return res;
    endfunction

    task automatic histogram_step(input t_request rq, output t_answer ans);
        longint      v;
        longint      w;
        longint      lo_o;
        longint      hi_o;
        logic [31:0] hc;
        logic [31:0] up;
        logic [31:0] low;
        longint      m;
        int          b;
        int          lw;
        int          hg;
        int          mid;
        logic        sat;
        v = sx(rq.sample);
        lo_o = 0;
        hi_o = 0;
        hc = '0;
        sat = 1'b0;
        case (rq.cmd)
            CMD_ADD: begin
                n_adds++;
                for (int i = 0; i < n_active(); i++) begin
                    if (v >= sx(cfg[REG_A_LOW + 2*i]) && v <= sx(cfg[REG_A_HIGH + 2*i]))
                        ihits[i] = inc32(ihits[i]);
                end
                if (v < edges[0]) b = -1;
                else if (v >= edges[nbins]) b = nbins;
                else begin
                    lw = 0;
                    hg = nbins;
                    while (hg - lw > 1) begin
                        mid = (hg + lw) / 2;
                        if (v < edges[mid]) hg = mid; else lw = mid;
                    end
                    b = lw;
                end
                if (b >= nbins) begin
                    if (nbins < NBINS) begin
                        w = sadd(edges[nbins], -edges[nbins - 1]);
                        edges[nbins + 1] = sadd(v, w);
                        counts[nbins] = '0;
                        b = nbins;
                        nbins++;
                    end else begin
                        sat = 1'b1;
                        b = nbins - 1;
                    end
                end else if (b < 0) begin
                    if (nbins < NBINS) begin
                        w = sadd(edges[0], -edges[1]);
                        for (int i = nbins + 1; i >= 1; i--) edges[i] = edges[i - 1];
                        for (int i = nbins; i >= 1; i--) counts[i] = counts[i - 1];
                        edges[0] = sadd(v, w);
                        counts[0] = '0;
                        nbins++;
                    end else sat = 1'b1;
                    b = 0;
                end
                counts[b] = inc32(counts[b]);
                total = inc32(total);
                lo_o = edges[b];
                hi_o = edges[b + 1];
                hc = counts[b];
                if (nbins < NBINS && 64'(hc) * 64'(hc) > 64'(total) &&
                    sadd(edges[b + 1], -edges[b]) > longint'(cfg[REG_MIN_SPLIT])) begin
                    n_splits++;
                    up = hc / 2;
                    low = hc - up;
                    m = split_edge(edges[b], edges[b + 1], low, hc);
                    for (int i = nbins + 1; i >= b + 2; i--) edges[i] = edges[i - 1];
                    for (int i = nbins; i >= b + 2; i--) counts[i] = counts[i - 1];
                    counts[b] = low;
                    counts[b + 1] = up;
                    edges[b + 1] = m;
                    nbins++;
                end
            end
            CMD_BAR: begin
                if (rq.index < nbins) begin
                    lo_o = edges[rq.index];
                    hi_o = edges[rq.index + 1];
                    hc = counts[rq.index];
                end
            end
            CMD_INTV: begin
                if (rq.index < n_active()) begin
                    lo_o = sx(cfg[REG_A_LOW + 2*rq.index]);
                    hi_o = sx(cfg[REG_A_HIGH + 2*rq.index]);
                    hc = ihits[rq.index];
                end
            end
            CMD_CLEAR: clear_counts();
            CMD_RANGE: restart_range();
            default: ;
        endcase
        ans.lo = 32'(lo_o);
        ans.hi = 32'(hi_o);
        ans.hits = hc;
        ans.total = total;
        ans.nbars = 7'(nbins);
        ans.sat = sat;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle <= cycle + 1;

    // request driver; each accepted request also runs the shadow model
    always @(posedge i_clk) begin
        t_answer  ans;
        t_request rq;
        if (i_in_valid && !o_in_stall) begin
            histogram_step({i_cmd, i_sample_value, i_index}, ans);
            answer_q = {answer_q, ans};
        end
        if ((!i_in_valid || !o_in_stall) && i_rst_n) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                rq = pending_q.pop_front();
                i_in_valid <= 1'b1;
                i_cmd <= rq.cmd;
                i_sample_value <= rq.sample;
                i_index <= rq.index;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output stall driver
    always @(posedge i_clk) begin
        t_answer ex;
        if (o_out_valid && !i_out_stall) begin
            n_results++;
            if (answer_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                ex = answer_q.pop_front();
                if (o_bar_low !== ex.lo) begin
                    $error("bar_low exp %h got %h", ex.lo, o_bar_low); errors++;
                end
                if (o_bar_high !== ex.hi) begin
                    $error("bar_high exp %h got %h", ex.hi, o_bar_high); errors++;
                end
                if (o_hit_count !== ex.hits) begin
                    $error("hit_count exp %0d got %0d", ex.hits, o_hit_count); errors++;
                end
                if (o_total_samples !== ex.total) begin
                    $error("total_samples exp %0d got %0d", ex.total, o_total_samples);
                    errors++;
                end
                if (o_bars_in_use !== ex.nbars) begin
                    $error("bars_in_use exp %0d got %0d", ex.nbars, o_bars_in_use);
                    errors++;
                end
                if (o_saturated !== ex.sat) begin
                    $error("saturated exp %0d got %0d", ex.sat, o_saturated); errors++;
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycle > 64'd3000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reg_write(input t_reg r, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(4 * r);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_MIN_SPLIT: cfg[r] = val & 32'h7fff_ffff;
            REG_NUM_INTV:  cfg[r] = val & 32'd3;
            default:       cfg[r] = val;
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || answer_q.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic t_request mk(logic [2:0] c, logic [31:0] s, int ix);
        t_request rq;
        rq.cmd = c;
        rq.sample = s;
        rq.index = 6'(ix);
        return rq;
    endfunction

    task automatic add_req(input t_request rq);
        pending_q = {pending_q, rq};
    endtask

    function automatic logic [31:0] rand_sample(int shape);
        case (shape)
            0: return 32'($urandom_range(131072));
            1: return 32'(int'($urandom_range(20000)) - 10000);
            2: return $urandom();
            default: return 32'(int'($urandom_range(400000)) - 200000);
        endcase
    endfunction

    task automatic random_phase(input int n, input int shape);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 70) add_req(mk(CMD_ADD, rand_sample(shape), $urandom()));
            else if (k < 82) add_req(mk(CMD_BAR, 0, $urandom_range(70) % 64));
            else if (k < 90) add_req(mk(CMD_INTV, $urandom(), $urandom_range(3)));
            else if (k < 93) add_req(mk(CMD_CLEAR, $urandom(), $urandom()));
            else if (k < 95) add_req(mk(CMD_RANGE, $urandom(), $urandom()));
            else if (k < 97) add_req(mk(3'($urandom_range(7, 5)), $urandom(), $urandom()));
            else add_req(mk(CMD_BAR, 0, $urandom()));
        end
    endtask

    initial begin
        cycle = 0;
        errors = 0;
        n_results = 0;
        n_adds = 0;
        n_splits = 0;
        hold_cycles = 0;
        send_idle_pct = 22;
        recv_idle_pct = 69;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_cmd = '0;
        i_sample_value = '0;
        i_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg[REG_INIT_LOW] = 32'd0;
        cfg[REG_INIT_HIGH] = 32'd65536;
        for (int i = 2; i < 8; i++) cfg[i] = '0;
        restart_range();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        reg_write(REG_NUM_INTV, 32'd3);
        reg_write(REG_A_LOW, 32'h8000_0000);
        reg_write(REG_A_HIGH, 32'd0);
        reg_write(REG_B_LOW, 32'd0);
        reg_write(REG_B_HIGH, 32'h7fff_ffff);
        // directed: extremes, all commands, out-of-range reads, ignored codes
        add_req(mk(CMD_ADD, 32'd100, 0));
        add_req(mk(CMD_ADD, 32'h7fff_ffff, 0));
        add_req(mk(CMD_ADD, 32'h8000_0000, 0));
        add_req(mk(CMD_ADD, 32'd0, 63));
        add_req(mk(CMD_ADD, 32'hffff_ffff, 0));
        add_req(mk(CMD_BAR, 0, 0));
        add_req(mk(CMD_BAR, 0, 1));
        add_req(mk(CMD_BAR, 0, 63));
        add_req(mk(CMD_INTV, 0, 0));
        add_req(mk(CMD_INTV, 0, 1));
        add_req(mk(CMD_INTV, 0, 2));
        add_req(mk(3'd5, 32'hffff_ffff, 63));
        add_req(mk(3'd7, 0, 0));
        add_req(mk(CMD_CLEAR, 0, 0));
        add_req(mk(CMD_BAR, 0, 0));
        add_req(mk(CMD_RANGE, 0, 0));
        // long hold-off on the output so the block backs up
        hold_cycles = 400;
        random_phase(20, 0);
        drain();
        // fill the store to saturation with spread-out samples
        for (int i = 0; i < 80; i++)
            add_req(mk(CMD_ADD, 32'(i * 200000 - 8000000), 0));
        add_req(mk(CMD_ADD, 32'h8000_0000, 0));
        add_req(mk(CMD_ADD, 32'h7fff_ffff, 0));
        random_phase(60, 2);
        drain();

        reg_write(REG_INIT_LOW, 32'hffff_0000);
        reg_write(REG_INIT_HIGH, 32'h0001_0000);
        reg_write(REG_MIN_SPLIT, 32'h0000_4000);
        reg_write(REG_NUM_INTV, 32'd2);
        reg_write(REG_A_LOW, 32'hffff_8000);
        reg_write(REG_A_HIGH, 32'h0000_8000);
        reg_write(REG_B_LOW, 32'd0);
        reg_write(REG_B_HIGH, 32'd0);
        add_req(mk(CMD_RANGE, 0, 0));
        random_phase(400, 1);
        drain();

        send_idle_pct = 69;
        recv_idle_pct = 22;
        reg_write(REG_MIN_SPLIT, 32'hffff_ffff);
        reg_write(REG_NUM_INTV, 32'd1);
        reg_write(REG_INIT_LOW, 32'h7fff_0000);
        reg_write(REG_INIT_HIGH, 32'h7fff_ffff);
        add_req(mk(CMD_RANGE, 0, 0));
        random_phase(200, 2);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        reg_write(REG_MIN_SPLIT, 32'd0);
        reg_write(REG_INIT_LOW, 32'h8000_0000);
        reg_write(REG_INIT_HIGH, 32'h8000_0100);
        add_req(mk(CMD_RANGE, 0, 0));
        random_phase(200, 3);
        drain();
        reg_write(REG_INIT_LOW, 32'd0);
        reg_write(REG_INIT_HIGH, 32'd65536);
        add_req(mk(CMD_RANGE, 0, 0));
        random_phase(300, 0);
        drain();

        $display("Covered %0d requests (%0d samples added, %0d bin splits).",
                 n_results, n_adds, n_splits);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> sim.f
hdl/ash_pkg.sv
hdl/ash_div.sv
hdl/adaptive_split_histogram.sv
bench/adaptive_split_histogram_tb.sv
